// ===== sv/phdc_pkg.sv =====
// shared types and constants for the packet header decoder with crc-32 checks
package phdc_pkg;

  // byte position counter and extended compare width
  localparam int unsigned PosW  = 16;
  localparam int unsigned PosXW = PosW + 1;
  localparam logic [PosW-1:0] PosMax = '1;

  // field widths
  localparam int unsigned LenW = 15;
  localparam int unsigned WinW = 5;
  localparam int unsigned CrcW = 32;

  // crc-32, reflected form
  localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

  // the truncated bit is masked out of byte 0 before it enters the header crc
  localparam logic [7:0] FirstByteCrcMask = 8'hDF;

  // header layout, offsets before the long-length adjustment
  localparam logic [PosXW-1:0] HdrCrcStart = 17'd7;
  localparam logic [PosXW-1:0] HdrEnd      = 17'd11;
  localparam logic [PosXW-1:0] CrcBytes    = 17'd4;

  // configuration register reset values
  localparam logic [WinW-1:0] WindowLimitRst  = 5'd31;
  localparam logic [LenW-1:0] PayloadLimitRst = 15'd512;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgWindowLimit  = 1'b0,
    CfgPayloadLimit = 1'b1
  } cfg_reg_e;

  // result status codes
  typedef enum logic [2:0] {
    StOk           = 3'd0,
    StInconsistent = 3'd1,
    StNoHeader     = 3'd2,
    StType         = 3'd3,
    StWindow       = 3'd4,
    StLength       = 3'd5,
    StCrc          = 3'd6
  } status_e;

  // one decoded packet result
  typedef struct packed {
    status_e          status;
    logic [1:0]       pkt_type;
    logic             truncated;
    logic [WinW-1:0]  window;
    logic [LenW-1:0]  payload_length;
    logic [7:0]       seqnum;
    logic [31:0]      timestamp;
    logic [CrcW-1:0]  header_crc;
    logic [CrcW-1:0]  payload_crc;
    logic             payload_crc_checked;
  } res_t;

endpackage

// ===== sv/packet_header_decoder_crc32_top.sv =====
// Packet deframer with header and payload CRC-32 checks.
// Input channel: one packet byte per word (data_byte_i) with last_byte_i on the
// final byte; in_valid_i/in_ready_o. Output channel: one result word per packet,
// status and decoded fields, out_valid_o/out_ready_i. Configuration channel:
// cfg_valid_i/cfg_ready_o with cfg_index_i (0 window limit, 1 payload limit)
// and cfg_data_i; always ready, write only while no packet is in flight.
// Throughput: one byte per cycle while no final byte stalls, set by the
// byte-wide CRC-32 update that sits between the input register and the packet state
// registers. An accepted byte is processed from the input register into the
// packet state; a last byte also loads the result register and out_valid_o.
// Reset: packet state clears, window limit returns to 31 and payload limit to
// 512, both channels empty.
// Receiver stall: non-final bytes keep flowing; a final byte waits in the input
// register while the previous result is still held, and the input stalls only
// behind it.
module packet_header_decoder_crc32_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic [1:0]                pkt_type_o,
  output logic                      truncated_o,
  output logic [phdc_pkg::WinW-1:0] window_o,
  output logic [phdc_pkg::LenW-1:0] payload_length_o,
  output logic [7:0]                seqnum_o,
  output logic [31:0]               timestamp_o,
  output logic [phdc_pkg::CrcW-1:0] header_crc_o,
  output logic [phdc_pkg::CrcW-1:0] payload_crc_o,
  output logic                      payload_crc_checked_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [0:0]                cfg_index_i,
  input  logic [phdc_pkg::LenW-1:0] cfg_data_i
);
  import phdc_pkg::*;

  logic            in_valid_q;
  logic [7:0]      in_data_q;
  logic            in_last_q;
  logic            out_valid_q;
  res_t            res_q, res;
  logic            out_free, fire;
  logic [WinW-1:0] window_limit_q;
  logic [LenW-1:0] payload_limit_q;

  // handshake control
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && (!in_last_q || out_free);
  assign in_ready_o = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_limit_q  <= WindowLimitRst;
      payload_limit_q <= PayloadLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgWindowLimit:  window_limit_q  <= cfg_data_i[WinW-1:0];
        CfgPayloadLimit: payload_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  phdc_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (fire),
    .data_i          (in_data_q),
    .last_i          (in_last_q),
    .window_limit_i  (window_limit_q),
    .payload_limit_i (payload_limit_q),
    .res_o           (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      res_q <= res;
    end
  end

  // result word ports
  assign out_valid_o           = out_valid_q;
  assign status_o              = res_q.status;
  assign pkt_type_o            = res_q.pkt_type;
  assign truncated_o           = res_q.truncated;
  assign window_o              = res_q.window;
  assign payload_length_o      = res_q.payload_length;
  assign seqnum_o              = res_q.seqnum;
  assign timestamp_o           = res_q.timestamp;
  assign header_crc_o          = res_q.header_crc;
  assign payload_crc_o         = res_q.payload_crc;
  assign payload_crc_checked_o = res_q.payload_crc_checked;

endmodule

// ===== sv/phdc_crc8.sv =====
// byte-wide crc-32 update, reflected polynomial
module phdc_crc8 (
  input  logic [phdc_pkg::CrcW-1:0] crc_i,
  input  logic [7:0]                data_i,
  output logic [phdc_pkg::CrcW-1:0] crc_o
);
  import phdc_pkg::*;

  // eight shift and conditional xor steps
  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {{(CrcW-8){1'b0}}, data_i};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {CrcW{c[0]}});
    end
    crc_o = c;
  end

endmodule

// ===== sv/phdc_parser.sv =====
// per-packet state: header field decode, crc regions and final status
module phdc_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                data_i,
  input  logic                      last_i,
  input  logic [phdc_pkg::WinW-1:0] window_limit_i,
  input  logic [phdc_pkg::LenW-1:0] payload_limit_i,
  output phdc_pkg::res_t            res_o
);
  import phdc_pkg::*;

  logic [PosW-1:0]  pos_q;
  logic             l_q, l_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [7:0]       b0_q, b0_d;
  logic [7:0]       seq_q, seq_d;
  logic [31:0]      ts_q, ts_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [CrcW-1:0]  rcv_q, rcv_d;
  logic [CrcW-1:0]  hcv_q, hcv_d;
  logic             err_q, err_d;

  logic [PosXW-1:0] p_x, l_x, ts_off, n;
  logic [PosXW-1:0] hdr_crc_end, rx_end, pay_end, tail_end, need;
  logic [7:0]       crc_data;
  logic [CrcW-1:0]  crc_upd, rcv_shift, pcrc;
  logic             chk;
  status_e          status;

  assign p_x    = {1'b0, pos_q};
  assign ts_off = p_x - (17'd3 + {{(PosXW-1){1'b0}}, l_q});

  // header field decode
  always_comb begin
    b0_d  = b0_q;
    l_d   = l_q;
    len_d = len_q;
    seq_d = seq_q;
    ts_d  = ts_q;
    priority if (pos_q == 16'd0) begin
      b0_d = data_i;
    end else if (pos_q == 16'd1) begin
      l_d   = data_i[7];
      len_d = data_i[7] ? {data_i[6:0], 8'h00} : {8'h00, data_i[6:0]};
    end else if (pos_q == 16'd2 && l_q) begin
      len_d[7:0] = data_i;
    end else if (p_x == 17'd2 + {{(PosXW-1){1'b0}}, l_q}) begin
      seq_d = data_i;
    end else if (p_x >= 17'd3 + {{(PosXW-1){1'b0}}, l_q} &&
                 p_x <= 17'd6 + {{(PosXW-1){1'b0}}, l_q}) begin
      unique case (ts_off[1:0])
        2'd0: ts_d[7:0]   = data_i;
        2'd1: ts_d[15:8]  = data_i;
        2'd2: ts_d[23:16] = data_i;
        2'd3: ts_d[31:24] = data_i;
        default: ts_d = ts_q;
      endcase
    end else begin
      // past the header fields, nothing to capture
      ts_d = ts_q;
    end
  end

  // region boundaries, with the freshly decoded length flag and length
  assign l_x         = {{(PosXW-1){1'b0}}, l_d};
  assign hdr_crc_end = HdrCrcStart + l_x;
  assign rx_end      = HdrEnd - 17'd1 + l_x;
  assign pay_end     = HdrEnd + l_x + {{(PosXW-LenW){1'b0}}, len_d};
  assign tail_end    = pay_end + CrcBytes;

  assign crc_data  = (pos_q == 16'd0) ? (data_i & FirstByteCrcMask) : data_i;
  assign rcv_shift = {rcv_q[CrcW-9:0], data_i};

  phdc_crc8 u_crc8 (
    .crc_i  (crc_q),
    .data_i (crc_data),
    .crc_o  (crc_upd)
  );

  // crc regions: header crc, received header crc, payload crc, received payload crc
  always_comb begin
    crc_d = crc_q;
    rcv_d = rcv_q;
    hcv_d = hcv_q;
    err_d = err_q;
    priority if (p_x < hdr_crc_end) begin
      crc_d = crc_upd;
      if (p_x == hdr_crc_end - 17'd1) begin
        hcv_d = ~crc_upd;
        crc_d = CrcInit;
      end
    end else if (p_x <= rx_end) begin
      rcv_d = rcv_shift;
      if (p_x == rx_end && rcv_shift != hcv_q) begin
        err_d = 1'b1;
      end
    end else if (p_x < pay_end) begin
      crc_d = crc_upd;
    end else if (p_x < tail_end) begin
      rcv_d = rcv_shift;
    end else begin
      // trailing bytes enter no crc
      rcv_d = rcv_q;
    end
  end

  // final status, first matching rule wins
  assign n    = p_x + 17'd1;
  assign chk  = (len_d != '0) && !b0_d[5];
  assign need = chk ? tail_end : pay_end;
  assign pcrc = ~crc_d;

  always_comb begin
    priority if (n < HdrCrcStart) begin
      status = StNoHeader;
    end else if (n < HdrEnd) begin
      status = StInconsistent;
    end else if (b0_d[7:6] == 2'd0) begin
      status = StType;
    end else if (b0_d[4:0] > window_limit_i) begin
      status = StWindow;
    end else if (len_d > payload_limit_i) begin
      status = StLength;
    end else if (n < HdrEnd + l_x) begin
      status = StInconsistent;
    end else if (err_d) begin
      status = StCrc;
    end else if (n < need) begin
      status = StInconsistent;
    end else if (chk && rcv_d != pcrc) begin
      status = StCrc;
    end else begin
      status = StOk;
    end
  end

  // the payload crc is reported only when the comparison was made
  logic checked;
  assign checked = chk && !err_d && (n >= need) && (n >= HdrEnd + l_x) &&
                   (status == StOk || status == StCrc);

  always_comb begin
    res_o.status              = status;
    res_o.pkt_type            = b0_d[7:6];
    res_o.truncated           = b0_d[5];
    res_o.window              = b0_d[4:0];
    res_o.payload_length      = len_d;
    res_o.seqnum              = seq_d;
    res_o.timestamp           = ts_d;
    res_o.header_crc          = hcv_d;
    res_o.payload_crc         = checked ? pcrc : '0;
    res_o.payload_crc_checked = checked;
  end

  // packet state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      l_q   <= 1'b0;
      len_q <= '0;
      b0_q  <= '0;
      seq_q <= '0;
      ts_q  <= '0;
      crc_q <= CrcInit;
      rcv_q <= '0;
      hcv_q <= '0;
      err_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q <= '0;
        l_q   <= 1'b0;
        len_q <= '0;
        b0_q  <= '0;
        seq_q <= '0;
        ts_q  <= '0;
        crc_q <= CrcInit;
        rcv_q <= '0;
        hcv_q <= '0;
        err_q <= 1'b0;
      end else begin
        pos_q <= (pos_q != PosMax) ? pos_q + 16'd1 : pos_q;
        l_q   <= l_d;
        len_q <= len_d;
        b0_q  <= b0_d;
        seq_q <= seq_d;
        ts_q  <= ts_d;
        crc_q <= crc_d;
        rcv_q <= rcv_d;
        hcv_q <= hcv_d;
        err_q <= err_d;
      end
    end
  end

endmodule

// ===== sv/phdc_checker.sv =====
// port-level checks for the packet header decoder, bound to the top level
module phdc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [2:0]                status_o,
  input logic                      truncated_o,
  input logic [phdc_pkg::LenW-1:0] payload_length_o,
  input logic [phdc_pkg::CrcW-1:0] payload_crc_o,
  input logic                      payload_crc_checked_o
);
  import phdc_pkg::*;

  // a stalled result word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result word dropped or changed while stalled");

  // status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StCrc)
    else $error("undefined status code");

  // a payload check ends in ok or crc error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_crc_checked_o |->
      (status_o == StOk || status_o == StCrc))
    else $error("payload crc checked with unexpected status");

  // no check without a payload or with the truncated bit set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_crc_checked_o |->
      (payload_length_o != '0) && !truncated_o)
    else $error("payload crc checked when not due");

  // an unchecked payload reports a zero crc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_crc_checked_o |-> payload_crc_o == '0)
    else $error("payload crc nonzero without a check");

endmodule

bind packet_header_decoder_crc32_top phdc_checker u_phdc_checker (.*);

// ===== tb/packet_header_decoder_crc32_top_tb.sv =====
// testbench for the packet header decoder: random packets checked against a crc-32 deframer
module packet_header_decoder_crc32_top_tb;
  import phdc_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          status_o;
  logic [1:0]          pkt_type_o;
  logic                truncated_o;
  logic [WinW-1:0]     window_o;
  logic [LenW-1:0]     payload_length_o;
  logic [7:0]          seqnum_o;
  logic [31:0]         timestamp_o;
  logic [CrcW-1:0]     header_crc_o;
  logic [CrcW-1:0]     payload_crc_o;
  logic                payload_crc_checked_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i = '0;
  logic [LenW-1:0]     cfg_data_i  = '0;

  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  cycle_count = 0;
  logic [7:0]          pkt_q[$];
  res_t                dut_res;

  packet_header_decoder_crc32_top dut (.*);

  // one byte through the reflected crc-32
  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    c ^= {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // deframer prediction and result checking
  class decode_scoreboard;
    logic [WinW-1:0] win_lim;
    logic [LenW-1:0] pay_lim;
    int              pos;
    int              long_len;
    logic [31:0]     run_crc;
    logic [31:0]     rx_crc;
    logic [31:0]     hdr_crc;
    logic            hdr_crc_bad;
    logic [7:0]      first_byte;
    logic [7:0]      seq;
    logic [31:0]     stamp;
    logic [LenW-1:0] pay_len;
    res_t            expected_q[$];
    int              errors;
    int              bytes_seen;
    int              results_checked;

    function new();
      win_lim = WindowLimitRst;
      pay_lim = PayloadLimitRst;
      clear_packet();
    endfunction

    function void clear_packet();
      pos         = 0;
      long_len    = 0;
      run_crc     = CrcInit;
      rx_crc      = '0;
      hdr_crc     = '0;
      hdr_crc_bad = 1'b0;
      first_byte  = '0;
      seq         = '0;
      stamp       = '0;
      pay_len     = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [LenW-1:0] data);
      case (idx)
        CfgWindowLimit:  win_lim = data[WinW-1:0];
        CfgPayloadLimit: pay_lim = data;
        default: ;
      endcase
    endfunction

    // advance the packet state by one accepted byte
    function void note_byte(logic [7:0] b, logic last);
      int   p;
      int   n;
      int   need;
      logic chk;
      res_t want;
      p = pos;
      bytes_seen++;

      // header field capture
      if (p == 0) begin
        first_byte = b;
      end else if (p == 1) begin
        long_len = b[7];
        pay_len  = b[7] ? {b[6:0], 8'h00} : {8'h00, b[6:0]};
      end else if (p == 2 && long_len == 1) begin
        pay_len[7:0] = b;
      end else if (p == 2 + long_len) begin
        seq = b;
      end else if (p >= 3 + long_len && p <= 6 + long_len) begin
        stamp[8*(p-3-long_len) +: 8] = b;
      end

      // crc regions: header, header crc, payload, payload crc
      if (p < 7 + long_len) begin
        run_crc = crc32_step(run_crc, (p == 0) ? (b & FirstByteCrcMask) : b);
        if (p == 6 + long_len) begin
          hdr_crc = ~run_crc;
          run_crc = CrcInit;
        end
      end else if (p <= 10 + long_len) begin
        rx_crc = {rx_crc[23:0], b};
        if (p == 10 + long_len && rx_crc != hdr_crc) hdr_crc_bad = 1'b1;
      end else if (p < 11 + long_len + int'(pay_len)) begin
        run_crc = crc32_step(run_crc, b);
      end else if (p < 15 + long_len + int'(pay_len)) begin
        rx_crc = {rx_crc[23:0], b};
      end

      if (pos < int'(PosMax)) pos++;
      if (!last) return;

      // final byte: decide the status, first failing rule wins
      n = p + 1;
      chk = (pay_len != 0) && !first_byte[5];
      want = '0;
      want.pkt_type       = first_byte[7:6];
      want.truncated      = first_byte[5];
      want.window         = first_byte[4:0];
      want.payload_length = pay_len;
      want.seqnum         = seq;
      want.timestamp      = stamp;
      want.header_crc     = hdr_crc;
      if (n < 7) want.status = StNoHeader;
      else if (n < 11) want.status = StInconsistent;
      else if (first_byte[7:6] == 2'd0) want.status = StType;
      else if (first_byte[4:0] > win_lim) want.status = StWindow;
      else if (pay_len > pay_lim) want.status = StLength;
      else if (n < 11 + long_len) want.status = StInconsistent;
      else if (hdr_crc_bad) want.status = StCrc;
      else begin
        need = 11 + long_len + int'(pay_len) + (chk ? 4 : 0);
        if (n < need) begin
          want.status = StInconsistent;
        end else if (chk) begin
          want.payload_crc         = ~run_crc;
          want.payload_crc_checked = 1'b1;
          want.status              = (rx_crc != ~run_crc) ? StCrc : StOk;
        end else begin
          want.status = StOk;
        end
      end
      expected_q.push_back(want);
      clear_packet();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one result word with the oldest expectation
    task check_result(res_t got);
      res_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report("result word with no packet pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.pkt_type !== want.pkt_type)
        report($sformatf("pkt_type %0d, want %0d", got.pkt_type, want.pkt_type));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %0d, want %0d", got.truncated, want.truncated));
      if (got.window !== want.window)
        report($sformatf("window %0d, want %0d", got.window, want.window));
      if (got.payload_length !== want.payload_length)
        report($sformatf("payload_length %0d, want %0d", got.payload_length,
                         want.payload_length));
      if (got.seqnum !== want.seqnum)
        report($sformatf("seqnum %h, want %h", got.seqnum, want.seqnum));
      if (got.timestamp !== want.timestamp)
        report($sformatf("timestamp %h, want %h", got.timestamp, want.timestamp));
      if (got.header_crc !== want.header_crc)
        report($sformatf("header_crc %h, want %h", got.header_crc, want.header_crc));
      if (got.payload_crc !== want.payload_crc)
        report($sformatf("payload_crc %h, want %h", got.payload_crc, want.payload_crc));
      if (got.payload_crc_checked !== want.payload_crc_checked)
        report($sformatf("payload_crc_checked %0d, want %0d", got.payload_crc_checked,
                         want.payload_crc_checked));
    endtask
  endclass

  decode_scoreboard sb = new();

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always_comb begin
    dut_res.status              = status_e'(status_o);
    dut_res.pkt_type            = pkt_type_o;
    dut_res.truncated           = truncated_o;
    dut_res.window              = window_o;
    dut_res.payload_length      = payload_length_o;
    dut_res.seqnum              = seqnum_o;
    dut_res.timestamp           = timestamp_o;
    dut_res.header_crc          = header_crc_o;
    dut_res.payload_crc         = payload_crc_o;
    dut_res.payload_crc_checked = payload_crc_checked_o;
  end

  // watch all three channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) sb.check_result(dut_res);
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // header, optional payload and crcs into pkt_q
  function automatic void build_packet(logic [1:0] ptype, logic trunc, logic [4:0] win,
                                       logic long_len, logic [LenW-1:0] len, int pay_bytes);
    logic [31:0] crc;
    int          hdr_end;
    pkt_q.delete();
    pkt_q.push_back({ptype, trunc, win});
    if (long_len) begin
      pkt_q.push_back({1'b1, len[14:8]});
      pkt_q.push_back(len[7:0]);
    end else begin
      pkt_q.push_back({1'b0, len[6:0]});
    end
    // seqnum and timestamp
    repeat (5) pkt_q.push_back(8'($urandom()));
    crc = CrcInit;
    foreach (pkt_q[i]) begin
      crc = crc32_step(crc, (i == 0) ? (pkt_q[i] & FirstByteCrcMask) : pkt_q[i]);
    end
    crc = ~crc;
    for (int k = 3; k >= 0; k--) pkt_q.push_back(crc[8*k +: 8]);
    hdr_end = pkt_q.size();
    repeat (pay_bytes) pkt_q.push_back(8'($urandom()));
    if (len != 0 && !trunc && pay_bytes == int'(len)) begin
      crc = CrcInit;
      for (int k = hdr_end; k < pkt_q.size(); k++) crc = crc32_step(crc, pkt_q[k]);
      crc = ~crc;
      for (int k = 3; k >= 0; k--) pkt_q.push_back(crc[8*k +: 8]);
    end
  endfunction

  // mostly legal lengths, some large, some over the limit
  function automatic int pick_length(int lim);
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range((lim < 40) ? lim : 40, 0);
    if (r < 80) return $urandom_range((lim < 700) ? lim : 700, 0);
    if (r < 90 || lim == 32767) return $urandom_range(32767, 0);
    return $urandom_range(32767, lim + 1);
  endfunction

  // random packet, returns the bytes that count (trailing junk excluded)
  function automatic int make_random_packet();
    int         r;
    int         len;
    int         cut;
    int         idx;
    int         counted;
    logic       long_len;
    logic       trunc;
    logic [4:0] win;
    logic [1:0] ptype;
    r = $urandom_range(99, 0);
    if (r < 5) begin
      pkt_q.delete();
      repeat ($urandom_range(30, 1)) pkt_q.push_back(8'($urandom()));
      return pkt_q.size();
    end
    len      = pick_length(int'(sb.pay_lim));
    long_len = (len > 127) ? 1'b1 : 1'($urandom());
    win      = ($urandom_range(99, 0) < 85) ? 5'($urandom_range(int'(sb.win_lim), 0))
                                            : 5'($urandom());
    ptype    = ($urandom_range(9, 0) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
    trunc    = ($urandom_range(3, 0) == 0);
    build_packet(ptype, trunc, win, long_len, LenW'(len),
                 (len > 700) ? $urandom_range(20, 0) : len);
    // damage: flip a byte or cut the packet short
    r = $urandom_range(99, 0);
    if (r < 15) begin
      idx = $urandom_range(pkt_q.size() - 1, 0);
      pkt_q[idx] ^= 8'($urandom_range(255, 1));
    end else if (r < 25) begin
      cut = $urandom_range(pkt_q.size(), 1);
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
    counted = pkt_q.size();
    if ($urandom_range(99, 0) < 15) repeat ($urandom_range(3, 1)) pkt_q.push_back(8'($urandom()));
    return counted;
  endfunction

  // one input word, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [LenW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // stop input and wait until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    // let the monitor see the last accepted byte first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int target);
    int sent;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < target) begin
      sent += make_random_packet();
      send_packet();
    end
  endtask

  // main sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lone byte, bare short header, long-length packet with payload check
    pkt_q.delete();
    pkt_q.push_back(8'hFF);
    send_packet();
    build_packet(2'd3, 1'b1, 5'd31, 1'b0, 15'd0, 0);
    send_packet();
    build_packet(2'd1, 1'b0, 5'd0, 1'b1, 15'd2, 2);
    send_packet();
    drain();

    // widest limits, junk in the unused window bits
    cfg_write(CfgWindowLimit, {10'($urandom()), 5'd31});
    cfg_write(CfgPayloadLimit, 15'd32767);
    cfg_valid_i <= 1'b0;
    run_phase(19, 54, 630);
    drain();

    // tightest limits
    cfg_write(CfgWindowLimit, {10'($urandom()), 5'd0});
    cfg_write(CfgPayloadLimit, 15'd0);
    cfg_valid_i <= 1'b0;
    run_phase(54, 19, 630);
    drain();

    // random limits, full rate
    cfg_write(CfgWindowLimit, 15'($urandom_range(30, 1)));
    cfg_write(CfgPayloadLimit, 15'($urandom_range(700, 16)));
    cfg_valid_i <= 1'b0;
    run_phase(0, 0, 640);
    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d bytes and %0d result words over three pacing phases",
             sb.bytes_seen, sb.results_checked);
    $display("limits: window 31/0/random, payload 512/32767/0/random, %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
